// ===== src/sch_pkg.sv =====
package sch_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int ARCTAN_STAGES = 16;

    localparam int GAIN_BITS = 16;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd13107;
    localparam int PRESCALE = 30;
    localparam int DEG_W = 9;
    localparam int FILT_W = DEG_W + FRACTION_BITS;
    localparam int CORDIC_W = 50;
    localparam int ANG_W = 50;
    localparam int IDX_W = (ARCTAN_STAGES > 1) ? $clog2(ARCTAN_STAGES) : 1;
    localparam int CNT_W = IDX_W;

    localparam logic signed [ANG_W-1:0] PICO_PER_DEG = 50'sd1000000000000;
    localparam logic signed [ANG_W-1:0] ANG_180 = 50'sd180000000000000;
    localparam logic signed [ANG_W-1:0] ANG_360 = 50'sd360000000000000;

    typedef struct packed {
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
    } t_in;

    typedef struct packed {
        logic [DEG_W-1:0] smoothed_degrees;
        logic [DEG_W-1:0] raw_degrees;
    } t_out;

    typedef struct packed {
        logic cap;
        logic prep;
        logic special;
        logic rot;
        logic wrap;
        logic div;
        logic fix;
        logic f_load;
        logic f_diff;
        logic f_unwrap;
        logic f_mul;
        logic f_acc;
        logic f_wrap;
        logic out_load;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic primed;
        logic out_busy;
    } t_sts;

    // atan(2^-i) in units of 1e-12 degree
    function automatic logic signed [ANG_W-1:0] f_arctan(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 50'sd45000000000000;
            5'd1:    v = 50'sd26565051177078;
            5'd2:    v = 50'sd14036243467926;
            5'd3:    v = 50'sd7125016348902;
            5'd4:    v = 50'sd3576334374997;
            5'd5:    v = 50'sd1789910608246;
            5'd6:    v = 50'sd895173710211;
            5'd7:    v = 50'sd447614170861;
            5'd8:    v = 50'sd223810500369;
            5'd9:    v = 50'sd111905677066;
            5'd10:   v = 50'sd55952891894;
            5'd11:   v = 50'sd27976452617;
            5'd12:   v = 50'sd13988227142;
            5'd13:   v = 50'sd6994113675;
            5'd14:   v = 50'sd3497056851;
            5'd15:   v = 50'sd1748528427;
            5'd16:   v = 50'sd874264214;
            5'd17:   v = 50'sd437132107;
            5'd18:   v = 50'sd218566053;
            5'd19:   v = 50'sd109283027;
            5'd20:   v = 50'sd54641513;
            5'd21:   v = 50'sd27320757;
            5'd22:   v = 50'sd13660378;
            5'd23:   v = 50'sd6830189;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/sch_ctrl.sv =====
module sch_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sch_pkg::t_sts i_sts,
    output sch_pkg::t_cmd o_cmd
);
    import sch_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_ROT    = 4'd2;
    localparam logic [3:0] S_WRAP   = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_FILT   = 4'd5;
    localparam logic [3:0] S_UNWRAP = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_ACC    = 4'd8;
    localparam logic [3:0] S_FWRAP  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_FIX    = 4'd11;

    localparam logic [CNT_W-1:0] LAST_ROT = CNT_W'(ARCTAN_STAGES - 1);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.idx  = r_cnt[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.special) begin
                    o_cmd.special = 1'b1;
                    n_state       = S_FILT;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                if (r_cnt == LAST_ROT) begin
                    n_state = S_WRAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_FILT;
            end
            S_FILT: begin
                if (!i_sts.primed) begin
                    o_cmd.f_load = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.f_diff = 1'b1;
                    n_state      = S_UNWRAP;
                end
            end
            S_UNWRAP: begin
                o_cmd.f_unwrap = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.f_mul = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.f_acc = 1'b1;
                n_state     = S_FWRAP;
            end
            S_FWRAP: begin
                o_cmd.f_wrap = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("accepted transfer did not start processing");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over a stalled result");

    a_rot_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && r_cnt == LAST_ROT) |=> (r_state == S_WRAP))
        else $error("rotation did not end after last stage");

    a_one_filter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.f_load, o_cmd.f_diff, o_cmd.f_unwrap, o_cmd.f_mul,
                    o_cmd.f_acc, o_cmd.f_wrap, o_cmd.out_load}) <= 1)
        else $error("more than one filter command at once");

endmodule

// ===== src/sch_dp.sv =====
module sch_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sch_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sch_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [sch_pkg::GAIN_BITS-1:0] i_cfg_data,
    input  sch_pkg::t_cmd                 i_cmd,
    output sch_pkg::t_sts                 o_sts
);
    import sch_pkg::*;

    localparam int DIFF_W = FILT_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_BITS + 1;
    localparam int SUM_W  = FILT_W + 2;

    // 1e12 = 2^12 * 5^12: drop the power of two, estimate from the top bits, correct by one
    localparam int POW2_SH  = 12;
    localparam int T1_W     = ANG_W - 1 - POW2_SH;
    localparam int EST_SH   = 20;
    localparam int T2_W     = T1_W - EST_SH;
    localparam int RECIP_W  = 25;
    localparam int RECIP_SH = 32;
    localparam int EST_P_W  = T2_W + RECIP_W;
    localparam int DDIV_W   = 28;
    localparam int BOUND_W  = DEG_W + 1 + DDIV_W;

    localparam logic [RECIP_W-1:0] RECIP   = 25'd18446744;
    localparam logic [DDIV_W-1:0]  DEG_DIV = 28'd244140625;

    localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(64'd180 << FRACTION_BITS);
    localparam logic signed [DIFF_W-1:0] FULL_D = DIFF_W'(64'd360 << FRACTION_BITS);
    localparam logic signed [SUM_W-1:0]  FULL_S = SUM_W'(64'd360 << FRACTION_BITS);

    logic [GAIN_BITS-1:0]       r_gain;
    logic                       r_primed;
    logic                       r_out_valid;
    t_out                       r_out;
    logic signed [15:0]         r_fx, r_fy;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ANG_W-1:0]    r_ang;
    logic [DEG_W-1:0]           r_raw;
    logic [FILT_W-1:0]          r_filt;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SUM_W-1:0]    r_sum;

    logic signed [16:0]         w_ax, w_ay, w_px, w_py;
    logic                       w_neg;
    logic signed [CORDIC_W-1:0] w_xs, w_ys;
    logic [T1_W-1:0]            w_t1;
    logic [T2_W-1:0]            w_t2;
    logic [EST_P_W-1:0]         w_est_p;
    logic [DEG_W-1:0]           w_est;
    logic [DEG_W:0]             w_raw_inc;
    logic [BOUND_W-1:0]         w_bound;
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [SUM_W-1:0]    w_step;
    logic [DEG_W-1:0]           w_special;
    logic [FILT_W-1:0]          w_raw_q;

    assign w_ax  = {r_fy[15], r_fy};
    assign w_ay  = -{r_fx[15], r_fx};
    assign w_neg = w_ax[16];
    assign w_px  = w_neg ? -w_ax : w_ax;
    assign w_py  = w_neg ? -w_ay : w_ay;

    assign w_xs   = r_x >>> i_cmd.idx;
    assign w_ys   = r_y >>> i_cmd.idx;

    assign w_t1      = r_ang[ANG_W-2:POW2_SH];
    assign w_t2      = w_t1[T1_W-1:EST_SH];
    assign w_est_p   = w_t2 * RECIP;
    assign w_est     = w_est_p[RECIP_SH +: DEG_W];
    assign w_raw_inc = {1'b0, r_raw} + 1'b1;
    assign w_bound   = w_raw_inc * DEG_DIV;

    assign w_raw_q = {r_raw, {FRACTION_BITS{1'b0}}};
    assign w_shift = r_prod >>> GAIN_BITS;
    assign w_step  = {{(SUM_W-DIFF_W){w_shift[DIFF_W-1]}}, w_shift[DIFF_W-1:0]};

    always_comb begin
        if (r_fx == 16'sd0) begin
            w_special = r_fy[15] ? 9'd180 : 9'd0;
        end else begin
            w_special = r_fx[15] ? 9'd90 : 9'd270;
        end
    end

    assign o_sts.special  = (r_fx == 16'sd0) || (r_fy == 16'sd0);
    assign o_sts.primed   = r_primed;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_filt      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.f_load) begin
                r_filt   <= w_raw_q;
                r_primed <= 1'b1;
            end else if (i_cmd.f_wrap) begin
                if (r_sum < 0) begin
                    r_filt <= FILT_W'(r_sum + FULL_S);
                end else if (r_sum >= FULL_S) begin
                    r_filt <= FILT_W'(r_sum - FULL_S);
                end else begin
                    r_filt <= FILT_W'(r_sum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_fx <= i_in_data.field_x;
            r_fy <= i_in_data.field_y;
        end
        if (i_cmd.prep) begin
            r_x   <= {{(CORDIC_W-17){w_px[16]}}, w_px} <<< PRESCALE;
            r_y   <= {{(CORDIC_W-17){w_py[16]}}, w_py} <<< PRESCALE;
            r_ang <= w_neg ? ANG_180 : '0;
        end else if (i_cmd.rot) begin
            if (r_y > 0) begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_ang <= r_ang + f_arctan(5'(i_cmd.idx));
            end else begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_ang <= r_ang - f_arctan(5'(i_cmd.idx));
            end
        end else if (i_cmd.wrap) begin
            if (r_ang < 0) begin
                r_ang <= r_ang + ANG_360;
            end
        end
        if (i_cmd.special) begin
            r_raw <= w_special;
        end else if (i_cmd.div) begin
            r_raw <= w_est;
        end else if (i_cmd.fix && (BOUND_W'(w_t1) >= w_bound)) begin
            r_raw <= w_raw_inc[DEG_W-1:0];
        end
        if (i_cmd.f_diff) begin
            r_diff <= $signed({1'b0, w_raw_q}) - $signed({1'b0, r_filt});
        end else if (i_cmd.f_unwrap) begin
            if (r_diff > HALF_D) begin
                r_diff <= r_diff - FULL_D;
            end else if (r_diff < -HALF_D) begin
                r_diff <= r_diff + FULL_D;
            end
        end
        if (i_cmd.f_mul) begin
            r_prod <= r_diff * $signed({1'b0, r_gain});
        end
        if (i_cmd.f_acc) begin
            r_sum <= $signed({2'b00, r_filt}) + w_step;
        end
        if (i_cmd.out_load) begin
            r_out.smoothed_degrees <= r_filt[FILT_W-1:FRACTION_BITS];
            r_out.raw_degrees      <= r_raw;
        end
    end

endmodule

// ===== src/smoothed_compass_heading.sv =====
// Smoothed compass heading.
// Input channel: i_in_valid / o_in_stall carry one magnetometer sample
// (field_x, field_y); a transfer happens on a clock edge with valid high and
// stall low. Output channel: o_out_valid / i_out_stall carry the smoothed and
// raw heading in whole degrees, one result per sample, in order.
// Configuration: i_cfg_we writes i_cfg_data into the smoothing gain (Q0.16)
// at any edge; write it only while the block is idle.
// Steps from the input transfer to o_out_valid for a general sample: check,
// one rotation per arctangent stage, wrap, an estimate and a correction step
// to turn the angle into whole degrees, five filter steps, output load. A
// sample on an axis needs no rotation and goes from the check to the filter;
// the first sample after reset loads the filter instead of the filter steps.
// One sample is in work at a time and o_in_stall is high meanwhile; the next
// transfer can come in the cycle after the output load.
// The output register holds a finished result while the receiver stalls;
// the next sample is taken meanwhile and waits before its output load.
// Reset sets the gain to 13107 and clears the filter state and o_out_valid.
module smoothed_compass_heading (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sch_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sch_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [sch_pkg::GAIN_BITS-1:0] i_cfg_data
);
    import sch_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sch_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ===== sim/smoothed_compass_heading_tb.sv =====
`timescale 1ns / 1ps

module smoothed_compass_heading_tb;
    import sch_pkg::*;

    localparam int PHASE_ITEMS = 220;
    localparam int CALM_ITEMS = 150;
    localparam int N_GAINS = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int ARC_LEN = 24;
    localparam longint PICO_DEG = 64'sd1000000000000;
    localparam longint HALF_TURN_PICO = 64'sd180000000000000;
    localparam longint FULL_TURN_PICO = 64'sd360000000000000;
    localparam longint FULL_TURN_Q = longint'(360) <<< FRACTION_BITS;
    localparam longint HALF_TURN_Q = longint'(180) <<< FRACTION_BITS;

    // atan(2^-i) in 1e-12 degree
    localparam longint ARC_PICO [ARC_LEN] = '{
        64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926,
        64'sd7125016348902, 64'sd3576334374997, 64'sd1789910608246,
        64'sd895173710211, 64'sd447614170861, 64'sd223810500369,
        64'sd111905677066, 64'sd55952891894, 64'sd27976452617,
        64'sd13988227142, 64'sd6994113675, 64'sd3497056851,
        64'sd1748528427, 64'sd874264214, 64'sd437132107,
        64'sd218566053, 64'sd109283027, 64'sd54641513,
        64'sd27320757, 64'sd13660378, 64'sd6830189
    };

    localparam logic signed [15:0] EDGE_VALS [6] = '{
        -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               has_raw;
        logic [DEG_W-1:0]   raw;
        logic               has_smooth;
        logic [DEG_W-1:0]   smooth;
    } t_dir_row;

    localparam int N_DIR = 24;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{16'sd0,      16'sd0,      1'b1, 9'd0,   1'b1, 9'd0},
        '{16'sd0,      16'sd1000,   1'b1, 9'd0,   1'b0, 9'd0},
        '{16'sd0,      -16'sd1000,  1'b1, 9'd180, 1'b0, 9'd0},
        '{-16'sd1000,  16'sd0,      1'b1, 9'd90,  1'b0, 9'd0},
        '{16'sd1000,   16'sd0,      1'b1, 9'd270, 1'b0, 9'd0},
        '{16'sd1,      16'sd32767,  1'b1, 9'd359, 1'b0, 9'd0},
        '{-16'sd1,     16'sd32767,  1'b1, 9'd0,   1'b0, 9'd0},
        '{-16'sd32768, 16'sd0,      1'b1, 9'd90,  1'b0, 9'd0},
        '{16'sd32767,  16'sd0,      1'b1, 9'd270, 1'b0, 9'd0},
        '{16'sd0,      -16'sd32768, 1'b1, 9'd180, 1'b0, 9'd0},
        '{16'sd0,      16'sd32767,  1'b1, 9'd0,   1'b0, 9'd0},
        '{16'sd0,      -16'sd1,     1'b1, 9'd180, 1'b0, 9'd0},
        '{16'sd1,      16'sd0,      1'b1, 9'd270, 1'b0, 9'd0},
        '{-16'sd1,     16'sd0,      1'b1, 9'd90,  1'b0, 9'd0},
        '{-16'sd32768, -16'sd32768, 1'b0, 9'd0,   1'b0, 9'd0},
        '{16'sd32767,  16'sd32767,  1'b0, 9'd0,   1'b0, 9'd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 9'd0,   1'b0, 9'd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 9'd0,   1'b0, 9'd0},
        '{-16'sd1,     -16'sd1,     1'b0, 9'd0,   1'b0, 9'd0},
        '{16'sd1,      16'sd1,      1'b0, 9'd0,   1'b0, 9'd0},
        '{-16'sd1,     16'sd1,      1'b0, 9'd0,   1'b0, 9'd0},
        '{16'sd1,      -16'sd1,     1'b0, 9'd0,   1'b0, 9'd0},
        '{-16'sd1,     -16'sd32768, 1'b0, 9'd0,   1'b0, 9'd0},
        '{16'sd1,      -16'sd32768, 1'b0, 9'd0,   1'b0, 9'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [GAIN_BITS-1:0] i_cfg_data = '0;

    t_out   heading_q[$];
    longint filt_q;
    bit     filt_loaded;
    int     gain_now;
    int     err_count = 0;
    bit     calm = 1'b0;
    logic signed [15:0] walk_x = 16'sd3000;
    logic signed [15:0] walk_y = 16'sd9000;

    smoothed_compass_heading DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("smoothed_compass_heading: mismatch");
        $finish;
    end

    function automatic int raw_heading(longint ax, longint ay);
        longint base, z, xr, yr, nx, ny, total;
        if (ay == 0) return (ax >= 0) ? 0 : 180;
        if (ax == 0) return (ay > 0) ? 90 : 270;
        base = 0;
        z = 0;
        if (ax < 0) begin
            ax = -ax;
            ay = -ay;
            base = HALF_TURN_PICO;
        end
        xr = ax <<< PRESCALE;
        yr = ay <<< PRESCALE;
        for (int i = 0; i < ARCTAN_STAGES && i < ARC_LEN; i++) begin
            if (yr > 0) begin
                nx = xr + (yr >>> i);
                ny = yr - (xr >>> i);
                z += ARC_PICO[i];
            end else begin
                nx = xr - (yr >>> i);
                ny = yr + (xr >>> i);
                z -= ARC_PICO[i];
            end
            xr = nx;
            yr = ny;
        end
        total = base + z;
        if (total < 0) total += FULL_TURN_PICO;
        if (total >= FULL_TURN_PICO) total -= FULL_TURN_PICO;
        return int'(total / PICO_DEG);
    endfunction

    function automatic t_out track_heading(t_in s);
        t_out   r;
        int     raw;
        longint raw_q, diff;
        raw = raw_heading(longint'(s.field_y), -longint'(s.field_x));
        raw_q = longint'(raw) <<< FRACTION_BITS;
        if (!filt_loaded) begin
            filt_q = raw_q;
            filt_loaded = 1'b1;
        end else begin
            diff = raw_q - filt_q;
            if (diff > HALF_TURN_Q) diff -= FULL_TURN_Q;
            if (diff < -HALF_TURN_Q) diff += FULL_TURN_Q;
            filt_q += (diff * longint'(gain_now)) >>> 16;
            if (filt_q < 0) filt_q += FULL_TURN_Q;
            if (filt_q >= FULL_TURN_Q) filt_q -= FULL_TURN_Q;
        end
        r.smoothed_degrees = DEG_W'(filt_q >>> FRACTION_BITS);
        r.raw_degrees = DEG_W'(raw);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_signed(int lo, int hi);
        return 16'(int'($urandom_range(0, hi - lo)) + lo);
    endfunction

    function automatic t_in pick_sample();
        t_in s;
        int  kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                s.field_x = 16'($urandom);
                s.field_y = 16'($urandom);
            end
            2, 3: begin
                walk_x = walk_x + rand_signed(-600, 600);
                walk_y = walk_y + rand_signed(-600, 600);
                s.field_x = walk_x;
                s.field_y = walk_y;
            end
            4: begin
                s.field_x = rand_signed(-4, 4);
                s.field_y = rand_signed(-4, 4);
            end
            5: begin
                s.field_x = $urandom_range(0, 1) ? 16'($urandom) : 16'sd0;
                s.field_y = (s.field_x == 0) ? 16'($urandom) : 16'sd0;
            end
            6: begin
                s.field_x = rand_signed(-3, 3);
                s.field_y = 16'($urandom);
                if ($urandom_range(0, 1)) {s.field_x, s.field_y} = {s.field_y, s.field_x};
            end
            7: begin
                s.field_x = EDGE_VALS[$urandom_range(0, 5)];
                s.field_y = EDGE_VALS[$urandom_range(0, 5)];
            end
            8: begin
                s.field_x = rand_signed(1, 300);
                if ($urandom_range(0, 1)) s.field_x = -s.field_x;
                s.field_y = rand_signed(20000, 32767);
            end
            default: begin
                s.field_x = rand_signed(1, 32767);
                s.field_y = s.field_x;
                if ($urandom_range(0, 1)) s.field_x = -s.field_x;
                if ($urandom_range(0, 1)) s.field_y = -s.field_y;
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("heading check @%0t: %s got %0d, want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic push_sample(t_in s, logic has_raw, logic [DEG_W-1:0] raw_want,
                               logic has_smooth, logic [DEG_W-1:0] smooth_want);
        t_out want;
        int   gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        do @(posedge i_clk); while (o_in_stall);
        want = track_heading(s);
        if (has_raw) want.raw_degrees = raw_want;
        if (has_smooth) want.smoothed_degrees = smooth_want;
        heading_q.push_back(want);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [GAIN_BITS-1:0] g);
        drain_results();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= g;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gain_now = int'(g);
    endtask

    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (burst > 0) burst--;
            else if (!calm && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 3);
            i_out_stall <= (burst > 0);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (heading_q.size() == 0) begin
                report_mismatch("result with nothing pending, raw", o_out_data.raw_degrees, -1);
            end else begin
                want = heading_q.pop_front();
                if (o_out_data.smoothed_degrees !== want.smoothed_degrees)
                    report_mismatch("smoothed_degrees", o_out_data.smoothed_degrees,
                                    want.smoothed_degrees);
                if (o_out_data.raw_degrees !== want.raw_degrees)
                    report_mismatch("raw_degrees", o_out_data.raw_degrees, want.raw_degrees);
            end
        end
    end

    initial begin
        logic [GAIN_BITS-1:0] gains [N_GAINS];
        t_in s;
        gains = '{16'd65535, 16'd1, 16'd0, 16'd32768, 16'd0, 16'd0, GAIN_RESET};
        gains[4] = 16'($urandom_range(1, 65535));
        gains[5] = 16'($urandom_range(1, 65535));
        gain_now = int'(GAIN_RESET);
        filt_q = 0;
        filt_loaded = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            s.field_x = DIR_ROWS[r].x;
            s.field_y = DIR_ROWS[r].y;
            push_sample(s, DIR_ROWS[r].has_raw, DIR_ROWS[r].raw,
                        DIR_ROWS[r].has_smooth, DIR_ROWS[r].smooth);
        end

        for (int p = 0; p < N_GAINS; p++) begin
            write_gain(gains[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == N_GAINS - 1 && n >= PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
                push_sample(pick_sample(), 1'b0, '0, 1'b0, '0);
            end
        end

        drain_results();
        if (err_count == 0) begin
            $display("smoothed_compass_heading: match");
        end else begin
            $display("smoothed_compass_heading: mismatch");
        end
        $finish;
    end

endmodule
